[rtl/core/twc_pkg.sv]
// ----------------------------------------------------------------------------
// twc_pkg: shared types and constants of the text window cursor engine
// Screen geometry, command and symbol codes, and the structs that run between
// the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package twc_pkg;

   // Screen geometry.
   localparam int ROWS         = 24;
   localparam int MAX_COLS     = 80;
   localparam int TAB_ZONE     = 16;
   localparam int DEFAULT_COLS = 40;

   // Card widths selected by the column switch.
   localparam logic [7:0] COLS_NARROW = 8'd40;
   localparam logic [7:0] COLS_WIDE   = 8'd80;

   // Characters and inverse masks.
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] MASK_NORMAL  = 8'hFF;
   localparam logic [7:0] MASK_FLASH   = 8'h7F;
   localparam logic [7:0] MASK_INVERSE = 8'h3F;
   localparam logic [7:0] SCREEN_HIGH  = 8'h80;
   localparam logic [7:0] SPC_LIMIT    = 8'd31;

   // Run buffer: up to RUN_SLOTS runs per command, kind + code + count.
   localparam int RUN_SLOTS = 63;
   localparam int RUN_DEPTH = RUN_SLOTS + 1;
   localparam int RUN_AW    = $clog2(RUN_DEPTH);
   localparam int RUN_W     = 3 + 8 + 7;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam logic CSR_CURSOR_MODE  = 1'b0;
   localparam logic CSR_PRINTER_MODE = 1'b1;

   // Poke targets.
   localparam logic [2:0] POKE_COL    = 3'd0;
   localparam logic [2:0] POKE_ROW    = 3'd1;
   localparam logic [2:0] POKE_LEFT   = 3'd2;
   localparam logic [2:0] POKE_WIDTH  = 3'd3;
   localparam logic [2:0] POKE_TOP    = 3'd4;
   localparam logic [2:0] POKE_BOTTOM = 3'd5;
   localparam logic [2:0] POKE_MASK   = 3'd6;

   // Text mode codes.
   localparam logic [1:0] TM_NORMAL  = 2'd0;
   localparam logic [1:0] TM_FLASH   = 2'd1;
   localparam logic [1:0] TM_INVERSE = 2'd2;

   typedef enum logic [4:0] {
      CMD_PUT      = 5'd0,
      CMD_RAW      = 5'd1,
      CMD_NEWLINE  = 5'd2,
      CMD_COMMA    = 5'd3,
      CMD_SPC      = 5'd4,
      CMD_TAB      = 5'd5,
      CMD_HTAB     = 5'd6,
      CMD_VTAB     = 5'd7,
      CMD_HOME     = 5'd8,
      CMD_EOL      = 5'd9,
      CMD_EOP      = 5'd10,
      CMD_WINTOP   = 5'd11,
      CMD_WINRESET = 5'd12,
      CMD_BOTTOM   = 5'd13,
      CMD_MODE     = 5'd14,
      CMD_COLS     = 5'd15,
      CMD_RESET    = 5'd16,
      CMD_POKE     = 5'd17,
      CMD_NOP      = 5'd18
   } cmd_type;

   typedef enum logic [2:0] {
      SYM_CHAR    = 3'd0,
      SYM_NEWLINE = 3'd1,
      SYM_CLEAR   = 3'd2,
      SYM_CLREOL  = 3'd3,
      SYM_CLREOP  = 3'd4,
      SYM_NONE    = 3'd5
   } sym_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FLUSH,
      ST_READ,
      ST_LOAD,
      ST_WAIT,
      ST_FINAL
   } state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] value;
      logic [2:0] sel;
   } item_type;

   typedef struct packed {
      logic cursor_mode;
      logic printer_mode;
   } cfg_type;

   typedef struct packed {
      sym_type    symbol_kind;
      logic [7:0] char_code;
      logic [7:0] screen_byte;
      logic [6:0] run_count;
      logic       last;
      logic [7:0] cursor_col;
      logic [7:0] cursor_row;
      logic [1:0] text_mode;
      logic       count_clipped;
   } rsp_type;

endpackage

[rtl/core/text_window_cursor_engine_unit.sv]
// ----------------------------------------------------------------------------
// text_window_cursor_engine_unit: text window cursor engine, top level
// Keeps a text cursor inside a clamped window and reports the screen symbols
// of each command as run-length words ending with a status word.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                          Direction  Handshake
//   request  req_kind/value/reg_select      in         req_valid / req_ready
//   response rsp_* (nine fields)            out        rsp_valid / rsp_ready
//   control  csr_index, csr_wdata           in         csr_we, no wait
//
// A command passes through intake, one execution step per symbol it sends
// plus a closing step, a flush of the open run, then a read, load and wait
// for each buffered run and a read, final and wait for the status word; the
// waits hold until rsp_ready. The execution sequencer and the single read
// port of the run buffer set this order. Reset is synchronous; the window
// returns to its default and no clearing pass is needed. The command queue
// holds two words, so it takes up to two requests while the response side stalls.
module text_window_cursor_engine_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_kind,
   input  logic [7:0] req_value,
   input  logic [2:0] req_reg_select,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_symbol_kind,
   output logic [7:0] rsp_char_code,
   output logic [7:0] rsp_screen_byte,
   output logic [6:0] rsp_run_count,
   output logic       rsp_last,
   output logic [7:0] rsp_cursor_col,
   output logic [7:0] rsp_cursor_row,
   output logic [1:0] rsp_text_mode,
   output logic       rsp_count_clipped,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic       csr_wdata
);

   twc_pkg::cfg_type  cfg_ff, cfg_in;
   twc_pkg::item_type q_item;
   twc_pkg::rsp_type  rsp;
   logic              q_valid, q_pop;

   // Control registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            twc_pkg::CSR_CURSOR_MODE:  cfg_in.cursor_mode  = csr_wdata;
            twc_pkg::CSR_PRINTER_MODE: cfg_in.printer_mode = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Intake and command queue.
   twc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_reg_select (req_reg_select),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // Execution and playback.
   twc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_symbol_kind   = rsp.symbol_kind;
   assign rsp_char_code     = rsp.char_code;
   assign rsp_screen_byte   = rsp.screen_byte;
   assign rsp_run_count     = rsp.run_count;
   assign rsp_last          = rsp.last;
   assign rsp_cursor_col    = rsp.cursor_col;
   assign rsp_cursor_row    = rsp.cursor_row;
   assign rsp_text_mode     = rsp.text_mode;
   assign rsp_count_clipped = rsp.count_clipped;

`ifndef SYNTHESIS
   // The status word carries no symbol.
   a_last_is_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> (rsp_symbol_kind == twc_pkg::SYM_NONE) &&
                                (rsp_run_count == 7'd0))
      else $error("status word carries a symbol");

   // A run word always repeats its symbol at least once.
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_run_count != 7'd0) &&
                                 (rsp_symbol_kind != twc_pkg::SYM_NONE))
      else $error("run word with empty count");

   // No new command is taken while a word is being delivered.
   a_no_pop_in_delivery: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !q_pop)
      else $error("command taken during delivery");
`endif

endmodule

[rtl/core/twc_ram.sv]
// ----------------------------------------------------------------------------
// twc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module twc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/core/twc_front.sv]
// ----------------------------------------------------------------------------
// twc_front: command intake and classification
// Takes request words, decodes the kind into a command code and holds the
// commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module twc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [4:0]         req_kind,
   input  logic [7:0]         req_value,
   input  logic [2:0]         req_reg_select,
   output logic               q_valid,
   output twc_pkg::item_type  q_item,
   input  logic               q_pop
);

   twc_pkg::item_type            entry_ff [twc_pkg::QUEUE_DEPTH];
   logic [twc_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [twc_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [twc_pkg::QUEUE_CW-1:0] count_ff, count_in;
   twc_pkg::cmd_type             cmd_dec;
   logic                         push;

   // Kind decoder; unused kinds become a no-op.
   always_comb begin
      unique case (req_kind)
         5'd0:    cmd_dec = twc_pkg::CMD_PUT;
         5'd1:    cmd_dec = twc_pkg::CMD_RAW;
         5'd2:    cmd_dec = twc_pkg::CMD_NEWLINE;
         5'd3:    cmd_dec = twc_pkg::CMD_COMMA;
         5'd4:    cmd_dec = twc_pkg::CMD_SPC;
         5'd5:    cmd_dec = twc_pkg::CMD_TAB;
         5'd6:    cmd_dec = twc_pkg::CMD_HTAB;
         5'd7:    cmd_dec = twc_pkg::CMD_VTAB;
         5'd8:    cmd_dec = twc_pkg::CMD_HOME;
         5'd9:    cmd_dec = twc_pkg::CMD_EOL;
         5'd10:   cmd_dec = twc_pkg::CMD_EOP;
         5'd11:   cmd_dec = twc_pkg::CMD_WINTOP;
         5'd12:   cmd_dec = twc_pkg::CMD_WINRESET;
         5'd13:   cmd_dec = twc_pkg::CMD_BOTTOM;
         5'd14:   cmd_dec = twc_pkg::CMD_MODE;
         5'd15:   cmd_dec = twc_pkg::CMD_COLS;
         5'd16:   cmd_dec = twc_pkg::CMD_RESET;
         5'd17:   cmd_dec = twc_pkg::CMD_POKE;
         default: cmd_dec = twc_pkg::CMD_NOP;
      endcase
   end

   // Queue handshake.
   assign req_ready = (count_ff != twc_pkg::QUEUE_CW'(twc_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == twc_pkg::QUEUE_AW'(twc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == twc_pkg::QUEUE_AW'(twc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{cmd: cmd_dec, value: req_value, sel: req_reg_select};
      end
   end

endmodule

[rtl/core/twc_back.sv]
// ----------------------------------------------------------------------------
// twc_back: command execution and result playback
// Holds the cursor and window state, steps each command one symbol per cycle
// into a run buffer, then plays the runs and the closing word out.
// ----------------------------------------------------------------------------
module twc_back (
   input  logic              clock,
   input  logic              reset,
   input  twc_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  twc_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output twc_pkg::rsp_type  rsp
);

   twc_pkg::state_type state_ff, state_in;

   // Cursor and window state.
   logic [7:0] col_ff, col_in, row_ff, row_in;
   logic [7:0] left_ff, left_in, width_ff, width_in;
   logic [7:0] top_ff, top_in, bottom_ff, bottom_in;
   logic [7:0] mask_ff, mask_in;
   logic       wide_ff, wide_in;

   // Pending work of the current command.
   logic              em_pend_ff, em_pend_in;
   twc_pkg::sym_type  em_kind_ff, em_kind_in;
   logic [7:0]        em_code_ff, em_code_in;
   logic              nl_pend_ff, nl_pend_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic [7:0]        ch_ff, ch_in;
   logic              vt_ff, vt_in;
   logic [7:0]        vt_val_ff, vt_val_in;
   logic              clipped_ff, clipped_in;

   // Open run and run buffer fill.
   logic              open_valid_ff, open_valid_in;
   twc_pkg::sym_type  open_kind_ff, open_kind_in;
   logic [7:0]        open_code_ff, open_code_in;
   logic [6:0]        open_cnt_ff, open_cnt_in;
   logic [twc_pkg::RUN_AW-1:0] nstored_ff, nstored_in;
   logic [twc_pkg::RUN_AW-1:0] idx_ff, idx_in;

   // Output word.
   twc_pkg::sym_type  out_kind_ff, out_kind_in;
   logic [7:0]        out_code_ff, out_code_in;
   logic [6:0]        out_cnt_ff, out_cnt_in;
   logic              out_last_ff, out_last_in;

   // Effective window.
   logic [7:0] eff_top, eff_bottom, eff_left, eff_width, bot_lim, wid_min, card_width;

   // Step decode.
   logic do_em, do_nl, do_put, do_vt, exec_busy;

   // Emit request and run buffer write.
   logic              e_valid;
   twc_pkg::sym_type  e_kind;
   logic [7:0]        e_code;
   logic              e_drop;
   logic              ram_we;
   logic [twc_pkg::RUN_AW-1:0] ram_waddr;
   logic [twc_pkg::RUN_W-1:0]  ram_wdata, ram_rdata;
   logic              ram_re;

   // Scratch values of the command setup.
   logic [8:0] zone_t;
   logic [7:0] tgt8;
   logic [7:0] vrow;

   // Effective window from the raw registers.
   always_comb begin
      eff_top   = (top_ff < 8'(twc_pkg::ROWS)) ? top_ff : 8'(twc_pkg::ROWS - 1);
      bot_lim   = (bottom_ff > 8'(twc_pkg::ROWS)) ? 8'(twc_pkg::ROWS) : bottom_ff;
      eff_bottom = (bot_lim <= eff_top) ? eff_top + 8'd1 : bot_lim;
      eff_left  = (left_ff < 8'(twc_pkg::MAX_COLS)) ? left_ff : 8'(twc_pkg::MAX_COLS - 1);
      wid_min   = (width_ff == 8'd0) ? 8'd1 : width_ff;
      eff_width = (({1'b0, eff_left} + {1'b0, wid_min}) > 9'(twc_pkg::MAX_COLS)) ?
                  8'(twc_pkg::MAX_COLS) - eff_left : wid_min;
      card_width = wide_ff ? twc_pkg::COLS_WIDE : twc_pkg::COLS_NARROW;
   end

   // One step per cycle: pending clear or raw symbol, pending newline,
   // a character of the put loop, or a downward newline of VTAB.
   always_comb begin
      do_em  = em_pend_ff;
      do_nl  = !em_pend_ff && nl_pend_ff;
      do_put = !em_pend_ff && !nl_pend_ff && (cnt_ff != 7'd0);
      do_vt  = !em_pend_ff && !nl_pend_ff && (cnt_ff == 7'd0) && vt_ff &&
               (({1'b0, row_ff} + 9'd1) < {1'b0, vt_val_ff}) &&
               (({1'b0, row_ff} + 9'd1) < {1'b0, eff_bottom});
      exec_busy = do_em || do_nl || do_put || do_vt;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twc_pkg::ST_IDLE:  if (q_valid) state_in = twc_pkg::ST_EXEC;
         twc_pkg::ST_EXEC:  if (!exec_busy) state_in = twc_pkg::ST_FLUSH;
         twc_pkg::ST_FLUSH: state_in = twc_pkg::ST_READ;
         twc_pkg::ST_READ:  state_in = (idx_ff == nstored_ff) ? twc_pkg::ST_FINAL :
                                                                twc_pkg::ST_LOAD;
         twc_pkg::ST_LOAD:  state_in = twc_pkg::ST_WAIT;
         twc_pkg::ST_WAIT: begin
            if (rsp_ready) begin
               state_in = out_last_ff ? twc_pkg::ST_IDLE : twc_pkg::ST_READ;
            end
         end
         twc_pkg::ST_FINAL: state_in = twc_pkg::ST_WAIT;
         default:           state_in = twc_pkg::ST_IDLE;
      endcase
   end

   assign q_pop  = (state_ff == twc_pkg::ST_IDLE) && q_valid;
   assign ram_re = (state_ff == twc_pkg::ST_READ) && (idx_ff != nstored_ff);

   // Printer filter: only newlines and printable characters pass.
   assign e_drop = cfg.printer_mode && (e_kind != twc_pkg::SYM_NEWLINE) &&
                   ((e_kind != twc_pkg::SYM_CHAR) || (e_code < twc_pkg::CHAR_SPACE));

   // Datapath and outputs of each state.
   always_comb begin
      col_in = col_ff;       row_in = row_ff;
      left_in = left_ff;     width_in = width_ff;
      top_in = top_ff;       bottom_in = bottom_ff;
      mask_in = mask_ff;     wide_in = wide_ff;
      em_pend_in = em_pend_ff; em_kind_in = em_kind_ff; em_code_in = em_code_ff;
      nl_pend_in = nl_pend_ff; cnt_in = cnt_ff; ch_in = ch_ff;
      vt_in = vt_ff;         vt_val_in = vt_val_ff;
      clipped_in = clipped_ff;
      open_valid_in = open_valid_ff; open_kind_in = open_kind_ff;
      open_code_in = open_code_ff;   open_cnt_in = open_cnt_ff;
      nstored_in = nstored_ff; idx_in = idx_ff;
      out_kind_in = out_kind_ff; out_code_in = out_code_ff;
      out_cnt_in = out_cnt_ff;   out_last_in = out_last_ff;
      e_valid = 1'b0;
      e_kind  = twc_pkg::SYM_CHAR;
      e_code  = 8'd0;
      ram_we  = 1'b0;
      ram_waddr = nstored_ff;
      ram_wdata = {open_kind_ff, open_code_ff, open_cnt_ff};
      zone_t = 9'(((col_ff / twc_pkg::TAB_ZONE) + 1) * twc_pkg::TAB_ZONE);
      tgt8   = (q_item.value > (eff_width - 8'd1)) ? eff_width - 8'd1 : q_item.value;
      vrow   = (q_item.value == 8'd0) ? 8'd1 :
               (q_item.value > 8'(twc_pkg::ROWS)) ? 8'(twc_pkg::ROWS) : q_item.value;

      unique case (state_ff)
         // Take a command: apply direct state changes and set up its steps.
         twc_pkg::ST_IDLE: begin
            if (q_valid) begin
               em_pend_in = 1'b0;
               nl_pend_in = 1'b0;
               cnt_in = 7'd0;
               vt_in = 1'b0;
               vt_val_in = q_item.value;
               clipped_in = 1'b0;
               open_valid_in = 1'b0;
               nstored_in = '0;
               idx_in = '0;
               ch_in = twc_pkg::CHAR_SPACE;
               em_code_in = 8'd0;
               unique case (q_item.cmd)
                  twc_pkg::CMD_PUT: begin
                     if (q_item.value == twc_pkg::CHAR_NEWLINE) begin
                        nl_pend_in = 1'b1;
                     end else begin
                        cnt_in = 7'd1;
                        ch_in  = q_item.value;
                     end
                  end
                  twc_pkg::CMD_RAW: begin
                     em_pend_in = 1'b1;
                     if (q_item.value == twc_pkg::CHAR_NEWLINE) begin
                        em_kind_in = twc_pkg::SYM_NEWLINE;
                     end else begin
                        em_kind_in = twc_pkg::SYM_CHAR;
                        em_code_in = q_item.value;
                     end
                  end
                  twc_pkg::CMD_NEWLINE: nl_pend_in = 1'b1;
                  twc_pkg::CMD_COMMA: begin
                     if (zone_t >= {1'b0, eff_width}) begin
                        nl_pend_in = 1'b1;
                     end else begin
                        cnt_in = 7'(zone_t - {1'b0, col_ff});
                     end
                  end
                  twc_pkg::CMD_SPC: begin
                     if (q_item.value > twc_pkg::SPC_LIMIT) begin
                        cnt_in = 7'(twc_pkg::SPC_LIMIT);
                        clipped_in = 1'b1;
                     end else begin
                        cnt_in = 7'(q_item.value);
                     end
                  end
                  twc_pkg::CMD_TAB: begin
                     if (tgt8 > col_ff) begin
                        cnt_in = 7'(tgt8 - col_ff);
                     end
                  end
                  twc_pkg::CMD_HTAB: begin
                     col_in = (q_item.value == 8'd0) ? 8'd0 : q_item.value - 8'd1;
                     if (col_in >= eff_width) begin
                        col_in = eff_width - 8'd1;
                     end
                  end
                  twc_pkg::CMD_VTAB: begin
                     if (cfg.cursor_mode) begin
                        row_in = vrow - 8'd1;
                     end else begin
                        vt_in = 1'b1;
                     end
                  end
                  twc_pkg::CMD_HOME: begin
                     col_in = 8'd0;
                     row_in = eff_top;
                     em_pend_in = 1'b1;
                     em_kind_in = twc_pkg::SYM_CLEAR;
                  end
                  twc_pkg::CMD_EOL: begin
                     em_pend_in = 1'b1;
                     em_kind_in = twc_pkg::SYM_CLREOL;
                  end
                  twc_pkg::CMD_EOP: begin
                     em_pend_in = 1'b1;
                     em_kind_in = twc_pkg::SYM_CLREOP;
                  end
                  twc_pkg::CMD_WINTOP: begin
                     top_in = (q_item.value >= 8'(twc_pkg::ROWS)) ?
                              8'(twc_pkg::ROWS - 1) : q_item.value;
                  end
                  twc_pkg::CMD_WINRESET: begin
                     left_in = 8'd0;
                     width_in = card_width;
                     top_in = 8'd0;
                     bottom_in = 8'(twc_pkg::ROWS);
                  end
                  twc_pkg::CMD_BOTTOM: begin
                     if (cfg.cursor_mode) begin
                        row_in = 8'(twc_pkg::ROWS - 1);
                     end
                  end
                  twc_pkg::CMD_MODE: begin
                     mask_in = (q_item.value == 8'd2) ? twc_pkg::MASK_INVERSE :
                               (q_item.value == 8'd1) ? twc_pkg::MASK_FLASH :
                                                        twc_pkg::MASK_NORMAL;
                  end
                  twc_pkg::CMD_COLS: begin
                     if (((q_item.value == twc_pkg::COLS_NARROW) ||
                          (q_item.value == twc_pkg::COLS_WIDE)) &&
                         (q_item.value != card_width)) begin
                        wide_in = (q_item.value == twc_pkg::COLS_WIDE);
                        left_in = 8'd0;
                        width_in = q_item.value;
                        top_in = 8'd0;
                        bottom_in = 8'(twc_pkg::ROWS);
                        col_in = 8'd0;
                        row_in = 8'd0;
                        em_pend_in = 1'b1;
                        em_kind_in = twc_pkg::SYM_CLEAR;
                     end
                  end
                  twc_pkg::CMD_RESET: begin
                     left_in = 8'd0;
                     width_in = card_width;
                     top_in = 8'd0;
                     bottom_in = 8'(twc_pkg::ROWS);
                     col_in = 8'd0;
                     row_in = 8'd0;
                     mask_in = twc_pkg::MASK_NORMAL;
                  end
                  twc_pkg::CMD_POKE: begin
                     case (q_item.sel)
                        twc_pkg::POKE_COL:    col_in = q_item.value;
                        twc_pkg::POKE_ROW:    row_in = q_item.value;
                        twc_pkg::POKE_LEFT:   left_in = q_item.value;
                        twc_pkg::POKE_WIDTH:  width_in = q_item.value;
                        twc_pkg::POKE_TOP:    top_in = q_item.value;
                        twc_pkg::POKE_BOTTOM: bottom_in = q_item.value;
                        twc_pkg::POKE_MASK:   mask_in = q_item.value;
                        default:              ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end

         // Execute one step of the command.
         twc_pkg::ST_EXEC: begin
            if (do_em) begin
               em_pend_in = 1'b0;
               e_valid = 1'b1;
               e_kind  = em_kind_ff;
               e_code  = em_code_ff;
            end else if (do_nl || do_vt) begin
               nl_pend_in = 1'b0;
               e_valid = 1'b1;
               e_kind  = twc_pkg::SYM_NEWLINE;
               col_in  = 8'd0;
               row_in  = (({1'b0, row_ff} + 9'd1) < {1'b0, eff_bottom}) ?
                         row_ff + 8'd1 : eff_bottom - 8'd1;
            end else if (do_put) begin
               e_valid = 1'b1;
               e_kind  = twc_pkg::SYM_CHAR;
               e_code  = ch_ff;
               col_in  = col_ff + 8'd1;
               cnt_in  = cnt_ff - 7'd1;
               if (col_in >= eff_width) begin
                  nl_pend_in = 1'b1;
               end
            end

            // Merge into the open run or, while run slots remain, open a new one.
            if (e_valid && !e_drop) begin
               if (open_valid_ff && (open_kind_ff == e_kind) && (open_code_ff == e_code)) begin
                  open_cnt_in = open_cnt_ff + 7'd1;
               end else if (({1'b0, nstored_ff} + 7'(open_valid_ff)) <
                            7'(twc_pkg::RUN_SLOTS)) begin
                  if (open_valid_ff) begin
                     ram_we = 1'b1;
                     nstored_in = nstored_ff + 1'b1;
                  end
                  open_valid_in = 1'b1;
                  open_kind_in = e_kind;
                  open_code_in = e_code;
                  open_cnt_in = 7'd1;
               end
            end
         end

         // Write the open run to the buffer.
         twc_pkg::ST_FLUSH: begin
            if (open_valid_ff) begin
               ram_we = 1'b1;
               nstored_in = nstored_ff + 1'b1;
               open_valid_in = 1'b0;
            end
         end

         twc_pkg::ST_READ: ;

         // Load a buffered run into the output word.
         twc_pkg::ST_LOAD: begin
            out_kind_in = twc_pkg::sym_type'(ram_rdata[twc_pkg::RUN_W-1 -: 3]);
            out_code_in = ram_rdata[14:7];
            out_cnt_in  = ram_rdata[6:0];
            out_last_in = 1'b0;
            idx_in = idx_ff + 1'b1;
         end

         twc_pkg::ST_WAIT: ;

         // Closing word of the command.
         twc_pkg::ST_FINAL: begin
            out_kind_in = twc_pkg::SYM_NONE;
            out_code_in = 8'd0;
            out_cnt_in  = 7'd0;
            out_last_in = 1'b1;
         end

         default: ;
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twc_pkg::ST_IDLE;
         col_ff <= 8'd0;
         row_ff <= 8'd0;
         left_ff <= 8'd0;
         width_ff <= 8'(twc_pkg::DEFAULT_COLS);
         top_ff <= 8'd0;
         bottom_ff <= 8'(twc_pkg::ROWS);
         mask_ff <= twc_pkg::MASK_NORMAL;
         wide_ff <= (twc_pkg::DEFAULT_COLS == 80);
         em_pend_ff <= 1'b0;
         nl_pend_ff <= 1'b0;
         cnt_ff <= 7'd0;
         vt_ff <= 1'b0;
         clipped_ff <= 1'b0;
         open_valid_ff <= 1'b0;
         nstored_ff <= '0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in;
         row_ff <= row_in;
         left_ff <= left_in;
         width_ff <= width_in;
         top_ff <= top_in;
         bottom_ff <= bottom_in;
         mask_ff <= mask_in;
         wide_ff <= wide_in;
         em_pend_ff <= em_pend_in;
         nl_pend_ff <= nl_pend_in;
         cnt_ff <= cnt_in;
         vt_ff <= vt_in;
         clipped_ff <= clipped_in;
         open_valid_ff <= open_valid_in;
         nstored_ff <= nstored_in;
         idx_ff <= idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      em_kind_ff <= em_kind_in;
      em_code_ff <= em_code_in;
      ch_ff <= ch_in;
      vt_val_ff <= vt_val_in;
      open_kind_ff <= open_kind_in;
      open_code_ff <= open_code_in;
      open_cnt_ff <= open_cnt_in;
      out_kind_ff <= out_kind_in;
      out_code_ff <= out_code_in;
      out_cnt_ff <= out_cnt_in;
      out_last_ff <= out_last_in;
   end

   // Run buffer.
   twc_ram #(
      .WIDTH (twc_pkg::RUN_W),
      .DEPTH (twc_pkg::RUN_DEPTH)
   ) u_runs (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // Result word; cursor fields come from the settled state.
   assign rsp_valid = (state_ff == twc_pkg::ST_WAIT);
   always_comb begin
      rsp.symbol_kind = out_kind_ff;
      rsp.char_code   = (out_kind_ff == twc_pkg::SYM_CHAR) ? out_code_ff : 8'd0;
      rsp.screen_byte = (out_kind_ff == twc_pkg::SYM_CHAR) ?
                        ((out_code_ff | twc_pkg::SCREEN_HIGH) & mask_ff) : 8'd0;
      rsp.run_count   = out_cnt_ff;
      rsp.last        = out_last_ff;
      rsp.cursor_col  = col_ff;
      rsp.cursor_row  = row_ff;
      rsp.text_mode   = mask_ff[7] ? twc_pkg::TM_NORMAL :
                        mask_ff[6] ? twc_pkg::TM_FLASH : twc_pkg::TM_INVERSE;
      rsp.count_clipped = clipped_ff;
   end

endmodule
